/* rtl/imuca_pkg.sv */
// Shared types, constants and helper functions for the complementary-filter
// attitude estimator. Used by every module of the block and by the checker.
package imuca_pkg;

  // Angle format and iteration counts.
  localparam int ANGLE_FRAC_BITS = 8;
  localparam int CORDIC_STEPS    = 16;
  localparam int Z_SHIFT         = 24 - ANGLE_FRAC_BITS;
  localparam int DIV_STEPS       = 3;
  localparam int WRAP_STEPS      = 8;
  localparam int CFG_IDX_W       = 8;

  // Rate integration divisor: 10^6 microseconds times the Q24-to-angle shift.
  localparam logic [35:0] RATE_DIV      = 36'(64'd1000000 * (64'd1 << Z_SHIFT));
  localparam logic [55:0] RATE_DIV_HALF = 56'(RATE_DIV >> 1);

  // The divisor splits into a power of two and the odd factor 15625; the odd
  // factor is handled by a reciprocal multiply and one correction step.
  localparam int          RATE_SHIFT = Z_SHIFT + 6;
  localparam logic [13:0] DIV_ODD    = 14'd15625;
  localparam logic [26:0] DIV_RECIP  = 27'd70368744;

  // Angle limits in the output format.
  localparam logic signed [23:0] ANG_FULL    = 24'(360 << ANGLE_FRAC_BITS);
  localparam logic signed [23:0] ANG_HALF    = 24'(180 << ANGLE_FRAC_BITS);
  localparam logic signed [23:0] ANG_QUARTER = 24'(90 << ANGLE_FRAC_BITS);

  // CORDIC constants in Q24 degrees and the Q16 CORDIC gain.
  localparam logic signed [33:0] Q24_90   = 34'sd1509949440;
  localparam logic [16:0]        GAIN_Q16 = 17'd107922;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGN      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_YAW_OFFSET = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_SCALE = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA      = 8'd3;

  // Mounting rotation codes.
  localparam logic [1:0] ALIGN_0   = 2'd0;
  localparam logic [1:0] ALIGN_90  = 2'd1;
  localparam logic [1:0] ALIGN_180 = 2'd2;
  localparam logic [1:0] ALIGN_270 = 2'd3;

  // Configuration reset values.
  localparam logic [23:0] GYRO_SCALE_RST = 24'd256140;
  localparam logic [15:0] ALPHA_RST      = 16'd64225;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic [15:0]        elapsed_us;
  } sample_t;

  typedef struct packed {
    logic signed [16:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic [16:0]        yaw_angle;
    logic               was_updated;
  } result_t;

  typedef struct packed {
    logic [1:0]         align_code;
    logic signed [15:0] yaw_rate_offset;
    logic [23:0]        gyro_scale;
    logic [15:0]        blend_alpha;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       capture;
    logic       load;
    logic       mul1;
    logic       mul2;
    logic       div_init;
    logic       div_step;
    logic       cordic_init;
    logic       cordic_sel;
    logic       cordic_step;
    logic [4:0] idx;
    logic       round;
    logic       blend1;
    logic       blend2;
    logic       wrap_step;
    logic       commit;
    logic       publish;
  } cmd_t;

  typedef struct packed {
    logic dt_zero;
  } status_t;

  // Negation that maps the most negative value to the most positive one.
  function automatic logic signed [15:0] neg_sat16(input logic signed [15:0] v);
    logic signed [15:0] r;
    if (v == 16'sh8000) r = 16'sh7fff;
    else r = -v;
    return r;
  endfunction

  // Saturate a 17-bit signed value to 16 bits.
  function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
    logic signed [15:0] r;
    if (v > 17'sd32767) r = 16'sh7fff;
    else if (v < -17'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  // Q24 degrees to output angle, rounding half away from zero.
  function automatic logic signed [17:0] q24_round(input logic signed [33:0] z);
    logic [33:0] m;
    logic [33:0] q;
    logic signed [17:0] r;
    m = z[33] ? 34'(-z) : 34'(z);
    q = (m + 34'(1 << (Z_SHIFT - 1))) >> Z_SHIFT;
    r = z[33] ? -$signed(18'(q)) : $signed(18'(q));
    return r;
  endfunction

  // atan(2^-i) in Q24 degrees.
  function automatic logic signed [33:0] atan_q24(input logic [4:0] i);
    logic signed [33:0] r;
    case (i)
      5'd0:    r = 34'sd754974720;
      5'd1:    r = 34'sd445687602;
      5'd2:    r = 34'sd235489088;
      5'd3:    r = 34'sd119537938;
      5'd4:    r = 34'sd60000934;
      5'd5:    r = 34'sd30029717;
      5'd6:    r = 34'sd15018523;
      5'd7:    r = 34'sd7509720;
      5'd8:    r = 34'sd3754917;
      5'd9:    r = 34'sd1877466;
      5'd10:   r = 34'sd938734;
      5'd11:   r = 34'sd469367;
      5'd12:   r = 34'sd234684;
      5'd13:   r = 34'sd117342;
      5'd14:   r = 34'sd58671;
      5'd15:   r = 34'sd29336;
      5'd16:   r = 34'sd14668;
      5'd17:   r = 34'sd7334;
      5'd18:   r = 34'sd3667;
      5'd19:   r = 34'sd1833;
      5'd20:   r = 34'sd917;
      5'd21:   r = 34'sd458;
      5'd22:   r = 34'sd229;
      5'd23:   r = 34'sd115;
      default: r = 34'sd0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/imuca_cfg.sv */
// Configuration register file of the attitude estimator.
// Depends on imuca_pkg for the register indexes and reset values.
module imuca_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic [imuca_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [23:0]                    cfg_data,
  output imuca_pkg::cfg_t                cfg
);

  // Writes to an index beyond the register list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.align_code      <= imuca_pkg::ALIGN_0;
      cfg.yaw_rate_offset <= '0;
      cfg.gyro_scale      <= imuca_pkg::GYRO_SCALE_RST;
      cfg.blend_alpha     <= imuca_pkg::ALPHA_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        imuca_pkg::CFG_ALIGN:      cfg.align_code      <= cfg_data[1:0];
        imuca_pkg::CFG_YAW_OFFSET: cfg.yaw_rate_offset <= cfg_data[15:0];
        imuca_pkg::CFG_GYRO_SCALE: cfg.gyro_scale      <= cfg_data;
        imuca_pkg::CFG_ALPHA:      cfg.blend_alpha     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/imuca_ctrl.sv */
// Sequencing state machine of the attitude estimator.
// Depends on imuca_pkg for the command and status structs.
module imuca_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  output logic                 sample_ready,
  output logic                 result_valid,
  input  logic                 result_ready,
  input  imuca_pkg::status_t   status,
  output imuca_pkg::cmd_t      cmd
);

  typedef enum logic [16:0] {
    S_IDLE   = 17'h00001,
    S_LOAD   = 17'h00002,
    S_MUL1   = 17'h00004,
    S_MUL2   = 17'h00008,
    S_DIVI   = 17'h00010,
    S_DIV    = 17'h00020,
    S_CR1I   = 17'h00040,
    S_CR1    = 17'h00080,
    S_CR2I   = 17'h00100,
    S_CR2    = 17'h00200,
    S_RND    = 17'h00400,
    S_BL1    = 17'h00800,
    S_BL2    = 17'h01000,
    S_WRAP   = 17'h02000,
    S_COMMIT = 17'h04000,
    S_PUB    = 17'h08000,
    S_DONE   = 17'h10000
  } state_t;

  state_t     state, state_next;
  logic [4:0] cnt, cnt_next;

  assign sample_ready = (state == S_IDLE);
  assign result_valid = (state == S_DONE);

  // Next state and step counter.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      S_IDLE: if (sample_valid) state_next = S_LOAD;
      S_LOAD: state_next = status.dt_zero ? S_PUB : S_MUL1;
      S_MUL1: state_next = S_MUL2;
      S_MUL2: state_next = S_DIVI;
      S_DIVI: begin
        state_next = S_DIV;
        cnt_next   = '0;
      end
      S_DIV: begin
        cnt_next = cnt + 5'd1;
        if (cnt == 5'(imuca_pkg::DIV_STEPS - 1)) state_next = S_CR1I;
      end
      S_CR1I: begin
        state_next = S_CR1;
        cnt_next   = '0;
      end
      S_CR1: begin
        cnt_next = cnt + 5'd1;
        if (cnt == 5'(imuca_pkg::CORDIC_STEPS - 1)) state_next = S_CR2I;
      end
      S_CR2I: begin
        state_next = S_CR2;
        cnt_next   = '0;
      end
      S_CR2: begin
        cnt_next = cnt + 5'd1;
        if (cnt == 5'(imuca_pkg::CORDIC_STEPS - 1)) state_next = S_RND;
      end
      S_RND: state_next = S_BL1;
      S_BL1: state_next = S_BL2;
      S_BL2: begin
        state_next = S_WRAP;
        cnt_next   = '0;
      end
      S_WRAP: begin
        cnt_next = cnt + 5'd1;
        if (cnt == 5'(imuca_pkg::WRAP_STEPS - 1)) state_next = S_COMMIT;
      end
      S_COMMIT: state_next = S_PUB;
      S_PUB:    state_next = S_DONE;
      S_DONE:   if (result_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Commands decoded from the current state.
  always_comb begin
    cmd             = '0;
    cmd.idx         = cnt;
    cmd.capture     = (state == S_IDLE) && sample_valid;
    cmd.load        = (state == S_LOAD);
    cmd.mul1        = (state == S_MUL1);
    cmd.mul2        = (state == S_MUL2);
    cmd.div_init    = (state == S_DIVI);
    cmd.div_step    = (state == S_DIV);
    cmd.cordic_init = (state == S_CR1I) || (state == S_CR2I);
    cmd.cordic_sel  = (state == S_CR2I);
    cmd.cordic_step = (state == S_CR1) || (state == S_CR2);
    cmd.round       = (state == S_RND);
    cmd.blend1      = (state == S_BL1);
    cmd.blend2      = (state == S_BL2);
    cmd.wrap_step   = (state == S_WRAP);
    cmd.commit      = (state == S_COMMIT);
    cmd.publish     = (state == S_PUB);
  end

endmodule

/* rtl/imuca_dp.sv */
// Datapath of the attitude estimator: axis remap, rate integration with a
// reciprocal-multiply divider, a shared CORDIC, blending and angle wrap.
// Depends on imuca_pkg for types, constants and helper functions.
module imuca_dp (
  input  logic                clk,
  input  logic                rst,
  input  imuca_pkg::sample_t  sample,
  input  imuca_pkg::cfg_t     cfg,
  input  imuca_pkg::cmd_t     cmd,
  output imuca_pkg::status_t  status,
  output imuca_pkg::result_t  result
);

  imuca_pkg::sample_t smp;

  // Remapped axes and lane registers (x, y, z rate lanes).
  logic signed [15:0] ax, ay, az;
  logic signed [15:0] gr [3];
  logic [15:0]        dt;
  logic               upd;
  logic               sgn [3];
  logic [39:0]        p1 [3];
  logic [55:0]        p2 [3];
  logic [32:0]        nq [3];
  logic [59:0]        rp [3];
  logic [19:0]        q0 [3];
  logic [20:0]        qr [3];
  logic               ax_neg;
  logic [32:0]        p_ax;
  logic signed [35:0] pitch_y0;

  // CORDIC registers.
  logic signed [35:0] cx, cy;
  logic signed [33:0] cz;
  logic               czero;
  logic signed [17:0] acc_roll, acc_pitch;

  // Blend and wrap registers.
  logic signed [41:0] pa_r, pb_r, pa_p, pb_p;
  logic signed [23:0] roll_w, pitch_w, yaw_w;

  // Estimator state.
  logic signed [16:0] roll_st;
  logic signed [15:0] pitch_st;
  logic [16:0]        yaw_st;

  assign status.dt_zero = (smp.elapsed_us == 16'd0);

  // Yaw bias removal and mounting rotation.
  logic signed [15:0] gz_n, rax, ray, rgx, rgy;
  always_comb begin
    gz_n = imuca_pkg::neg_sat16(imuca_pkg::sat16(
             17'(smp.rate_z) - 17'(cfg.yaw_rate_offset)));
    rax = smp.accel_x;
    ray = smp.accel_y;
    rgx = smp.rate_x;
    rgy = smp.rate_y;
    case (cfg.align_code)
      imuca_pkg::ALIGN_90: begin
        rax = smp.accel_y;
        ray = imuca_pkg::neg_sat16(smp.accel_x);
        rgx = smp.rate_y;
        rgy = imuca_pkg::neg_sat16(smp.rate_x);
      end
      imuca_pkg::ALIGN_180: begin
        rax = imuca_pkg::neg_sat16(smp.accel_x);
        ray = imuca_pkg::neg_sat16(smp.accel_y);
        rgx = imuca_pkg::neg_sat16(smp.rate_x);
        rgy = imuca_pkg::neg_sat16(smp.rate_y);
      end
      imuca_pkg::ALIGN_270: begin
        rax = imuca_pkg::neg_sat16(smp.accel_y);
        ray = smp.accel_x;
        rgx = imuca_pkg::neg_sat16(smp.rate_y);
        rgy = smp.rate_x;
      end
      default: ;
    endcase
  end

  // Divider correction: the estimate is low by at most one, so one remainder
  // check finishes the quotient. Signed rate deltas follow.
  logic [33:0]        rc [3];
  logic               up [3];
  logic signed [21:0] delta [3];
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      rc[l]    = 34'(nq[l]) - 34'(q0[l]) * 34'(imuca_pkg::DIV_ODD);
      up[l]    = (rc[l] >= 34'(imuca_pkg::DIV_ODD));
      delta[l] = sgn[l] ? -$signed({1'b0, qr[l]}) : $signed({1'b0, qr[l]});
    end
  end

  // CORDIC start vector and one micro-rotation.
  logic signed [35:0] x0, y0, dx, dy;
  always_comb begin
    if (cmd.cordic_sel) begin
      x0 = cx;
      y0 = pitch_y0;
    end else begin
      x0 = 36'(az) <<< 14;
      y0 = 36'(ay) <<< 14;
    end
    dx = cy >>> cmd.idx;
    dy = cx >>> cmd.idx;
  end

  // Blend sums rounded half away from zero.
  logic signed [42:0] sum_r, sum_p;
  logic signed [23:0] roll_b, pitch_b;
  logic [42:0]        mag_r, mag_p;
  always_comb begin
    sum_r  = 43'(pa_r) + 43'(pb_r);
    sum_p  = 43'(pa_p) + 43'(pb_p);
    mag_r  = sum_r[42] ? 43'(-sum_r) : 43'(sum_r);
    mag_p  = sum_p[42] ? 43'(-sum_p) : 43'(sum_p);
    roll_b = sum_r[42] ? -$signed(24'((mag_r + 43'd32768) >> 16))
                       : $signed(24'((mag_r + 43'd32768) >> 16));
    pitch_b = sum_p[42] ? -$signed(24'((mag_p + 43'd32768) >> 16))
                        : $signed(24'((mag_p + 43'd32768) >> 16));
  end

  // Gyro angles and blend weights.
  logic signed [23:0] roll_g, pitch_g;
  logic signed [17:0] alpha_s, beta_s;
  always_comb begin
    roll_g  = 24'(roll_st) + 24'(delta[0]);
    pitch_g = 24'(pitch_st) + 24'(delta[1]);
    alpha_s = $signed({2'b00, cfg.blend_alpha});
    beta_s  = $signed(18'(18'd65536 - {2'b00, cfg.blend_alpha}));
  end

  // Pipeline registers of the datapath.
  always_ff @(posedge clk) begin
    if (cmd.capture) smp <= sample;

    if (cmd.load) begin
      ax    <= rax;
      ay    <= ray;
      az    <= smp.accel_z;
      gr[0] <= rgx;
      gr[1] <= rgy;
      gr[2] <= gz_n;
      dt    <= smp.elapsed_us;
      upd   <= !status.dt_zero;
    end

    // Rate magnitude times scale, and the gain-scaled accel X.
    if (cmd.mul1) begin
      for (int l = 0; l < 3; l++) begin
        sgn[l] <= gr[l][15];
        p1[l]  <= 40'($unsigned(gr[l][15] ? -gr[l] : gr[l])) * 40'(cfg.gyro_scale);
      end
      ax_neg <= ax[15];
      p_ax   <= 33'($unsigned(ax[15] ? -ax : ax)) * 33'(imuca_pkg::GAIN_Q16);
    end

    if (cmd.mul2) begin
      for (int l = 0; l < 3; l++) p2[l] <= 56'(p1[l]) * 56'(dt);
      pitch_y0 <= ax_neg ? $signed(36'((p_ax + 33'd2) >> 2))
                         : -$signed(36'((p_ax + 33'd2) >> 2));
    end

    // Rounded divide: shift out the power of two, then multiply by the
    // reciprocal of the odd factor and correct the estimate.
    if (cmd.div_init) begin
      for (int l = 0; l < 3; l++)
        nq[l] <= 33'((p2[l] + imuca_pkg::RATE_DIV_HALF) >> imuca_pkg::RATE_SHIFT);
    end else if (cmd.div_step) begin
      case (cmd.idx)
        5'd0: for (int l = 0; l < 3; l++)
          rp[l] <= 60'(nq[l]) * 60'(imuca_pkg::DIV_RECIP);
        5'd1: for (int l = 0; l < 3; l++) q0[l] <= rp[l][59:40];
        default: for (int l = 0; l < 3; l++) qr[l] <= {1'b0, q0[l]} + 21'(up[l]);
      endcase
    end

    // Shared CORDIC in vectoring mode.
    if (cmd.cordic_init) begin
      if (cmd.cordic_sel) acc_roll <= imuca_pkg::q24_round(cz);
      if (x0 == 36'sd0 && y0 == 36'sd0) begin
        cx    <= '0;
        cy    <= '0;
        cz    <= '0;
        czero <= 1'b1;
      end else if (x0 < 36'sd0) begin
        czero <= 1'b0;
        if (y0 >= 36'sd0) begin
          cx <= y0;
          cy <= -x0;
          cz <= imuca_pkg::Q24_90;
        end else begin
          cx <= -y0;
          cy <= x0;
          cz <= -imuca_pkg::Q24_90;
        end
      end else begin
        czero <= 1'b0;
        cx    <= x0;
        cy    <= y0;
        cz    <= '0;
      end
    end else if (cmd.cordic_step && !czero) begin
      if (cy >= 36'sd0) begin
        cx <= cx + dx;
        cy <= cy - dy;
        cz <= cz + imuca_pkg::atan_q24(cmd.idx);
      end else begin
        cx <= cx - dx;
        cy <= cy + dy;
        cz <= cz - imuca_pkg::atan_q24(cmd.idx);
      end
    end

    if (cmd.round) acc_pitch <= imuca_pkg::q24_round(cz);

    if (cmd.blend1) begin
      pa_r  <= 42'(alpha_s * roll_g);
      pb_r  <= 42'(beta_s * acc_roll);
      pa_p  <= 42'(alpha_s * pitch_g);
      pb_p  <= 42'(beta_s * acc_pitch);
      yaw_w <= $signed(24'(yaw_st)) + 24'(delta[2]);
    end

    if (cmd.blend2) begin
      roll_w <= roll_b;
      if (pitch_b > imuca_pkg::ANG_QUARTER) pitch_w <= imuca_pkg::ANG_QUARTER;
      else if (pitch_b < -imuca_pkg::ANG_QUARTER) pitch_w <= -imuca_pkg::ANG_QUARTER;
      else pitch_w <= pitch_b;
    end

    // One turn of wrap per cycle on roll and yaw.
    if (cmd.wrap_step) begin
      if (roll_w > imuca_pkg::ANG_HALF) roll_w <= roll_w - imuca_pkg::ANG_FULL;
      else if (roll_w < -imuca_pkg::ANG_HALF) roll_w <= roll_w + imuca_pkg::ANG_FULL;
      if (yaw_w >= imuca_pkg::ANG_FULL) yaw_w <= yaw_w - imuca_pkg::ANG_FULL;
      else if (yaw_w < 24'sd0) yaw_w <= yaw_w + imuca_pkg::ANG_FULL;
    end

    if (cmd.publish) begin
      result.roll_angle  <= roll_st;
      result.pitch_angle <= pitch_st;
      result.yaw_angle   <= yaw_st;
      result.was_updated <= upd;
    end
  end

  // Estimator state, cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      roll_st  <= '0;
      pitch_st <= '0;
      yaw_st   <= '0;
    end else if (cmd.commit) begin
      roll_st  <= roll_w[16:0];
      pitch_st <= pitch_w[15:0];
      yaw_st   <= yaw_w[16:0];
    end
  end

endmodule

/* rtl/imu_complementary_attitude_top.sv */
// Complementary-filter attitude estimator, top level.
// A new word is accepted only while idle, so one word is in flight at a time;
// a word with elapsed_us zero skips straight to publishing the unchanged angles.
// The sequence holds two 16-step CORDIC passes and the wrap.
// Reset (synchronous) clears the angles to zero and loads register defaults.
// Depends on imuca_pkg, imuca_cfg, imuca_ctrl and imuca_dp.
module imu_complementary_attitude_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            sample_valid,
  output logic                            sample_ready,
  input  imuca_pkg::sample_t              sample,
  output logic                            result_valid,
  input  logic                            result_ready,
  output imuca_pkg::result_t              result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [imuca_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [23:0]                     cfg_data
);

  imuca_pkg::cfg_t    cfg;
  imuca_pkg::cmd_t    cmd;
  imuca_pkg::status_t status;

  // Register writes are taken in any cycle.
  assign cfg_ready = 1'b1;

  imuca_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  imuca_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .cmd          (cmd)
  );

  imuca_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .sample (sample),
    .cfg    (cfg),
    .cmd    (cmd),
    .status (status),
    .result (result)
  );

endmodule

/* rtl/imuca_checker.sv */
// Port-level checks for the attitude estimator, bound to the top level.
// Depends on imuca_pkg for the result type and angle limits.
module imuca_props (
  input logic               clk,
  input logic               rst,
  input logic               sample_valid,
  input logic               sample_ready,
  input logic               result_valid,
  input logic               result_ready,
  input imuca_pkg::result_t result
);

  // A waiting result word holds until taken.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result word changed while stalled");

  // Only one word is in flight: no new word right after one is taken.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> !sample_ready)
    else $error("input taken while busy");

  // Input is never accepted while a result waits.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !sample_ready)
    else $error("input ready while result pending");

  // Angles stay within their ranges.
  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ($signed(result.pitch_angle) <= 16'sd23040) &&
                     ($signed(result.pitch_angle) >= -16'sd23040))
    else $error("pitch out of range");

  a_yaw_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.yaw_angle < 17'(imuca_pkg::ANG_FULL)))
    else $error("yaw out of range");

endmodule

bind imu_complementary_attitude_top imuca_props u_imuca_props (.*);

/* dv/imuca_checker.sv */
// Attitude checker: watches the sample, result and register channels of the
// estimator, predicts each result word and compares it field by field.
// Depends on imuca_pkg for the word types and register indexes.
module imuca_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            sample_valid,
  input  logic                            sample_ready,
  input  imuca_pkg::sample_t              sample,
  input  logic                            result_valid,
  input  logic                            result_ready,
  input  imuca_pkg::result_t              result,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [imuca_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [23:0]                     cfg_data,
  output int                              fail_count,
  output int                              pending,
  output int                              result_count
);
  import imuca_pkg::*;

  // Shadow copy of the registers and the three angle accumulators.
  logic [1:0]          mount_code;
  logic signed [15:0]  yaw_bias;
  logic [23:0]         rate_gain;
  logic [15:0]         alpha_w;
  longint              roll_st, pitch_st, yaw_st;
  result_t             attitude_q[$];

  // Table of atan(2^-i) in Q24 degrees.
  longint arctan_tab[24] = '{754974720, 445687602, 235489088, 119537938, 60000934,
    30029717, 15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
    58671, 29336, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

  function automatic longint clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  // Division rounding half away from zero.
  function automatic longint div_round(longint n, longint d);
    longint m, q;
    m = (n < 0) ? -n : n;
    q = (m + d / 2) / d;
    return (n < 0) ? -q : q;
  endfunction

  // Vectoring CORDIC: returns the Q24 angle, magnitude through mag.
  function automatic longint vec_angle(longint x0, longint y0, output longint mag);
    longint x, y, z, t, dx, dy;
    x = x0; y = y0; z = 0;
    if (x == 0 && y == 0) begin
      mag = 0;
      return 0;
    end
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 1509949440;
      end else begin
        x = -y; y = t; z = -1509949440;
      end
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += arctan_tab[i];
      end else begin
        x -= dx; y += dy; z -= arctan_tab[i];
      end
    end
    mag = x;
    return z;
  endfunction

  function automatic longint rate_step(longint r, longint dt);
    return div_round(r * longint'(rate_gain) * dt, 64'd1000000 << Z_SHIFT);
  endfunction

  function automatic longint mix(longint g, longint a);
    longint w;
    w = longint'(alpha_w);
    return div_round(w * g + (65536 - w) * a, 65536);
  endfunction

  // Advance the estimate by one sample word and return the expected result word.
  function automatic result_t predict_attitude(sample_t s);
    longint one, full, half, quarter;
    longint ax, ay, az, gx, gy, gz, dt, t, r, p, y, mg, mg2, ar, ap, k;
    result_t o;
    one = 1 << ANGLE_FRAC_BITS;
    full = 360 * one; half = 180 * one; quarter = 90 * one;
    ax = s.accel_x; ay = s.accel_y; az = s.accel_z;
    gx = s.rate_x; gy = s.rate_y; gz = s.rate_z;
    dt = s.elapsed_us;
    o.was_updated = 1'b0;
    if (dt != 0) begin
      gz = clip16(-clip16(gz - longint'(yaw_bias)));
      case (mount_code)
        ALIGN_90: begin
          t = ax; ax = ay; ay = clip16(-t);
          t = gx; gx = gy; gy = clip16(-t);
        end
        ALIGN_180: begin
          ax = clip16(-ax); ay = clip16(-ay);
          gx = clip16(-gx); gy = clip16(-gy);
        end
        ALIGN_270: begin
          t = ax; ax = clip16(-ay); ay = t;
          t = gx; gx = clip16(-gy); gy = t;
        end
        default: ;
      endcase
      r = roll_st + rate_step(gx, dt);
      p = pitch_st + rate_step(gy, dt);
      y = yaw_st + rate_step(gz, dt);
      ar = div_round(vec_angle(az * 16384, ay * 16384, mg), 1 << Z_SHIFT);
      ap = div_round(vec_angle(mg, div_round(-ax * 16384 * 107922, 65536), mg2),
                     1 << Z_SHIFT);
      r = mix(r, ar);
      p = mix(p, ap);
      if (p > quarter) p = quarter;
      if (p < -quarter) p = -quarter;
      if (r > half) begin
        k = (r - half + full - 1) / full;
        r -= k * full;
      end else if (r < -half) begin
        k = (-half - r + full - 1) / full;
        r += k * full;
      end
      if (y >= full) y = y % full;
      else if (y < 0) y = full - 1 - ((-y - 1) % full);
      roll_st = r; pitch_st = p; yaw_st = y;
      o.was_updated = 1'b1;
    end
    o.roll_angle  = roll_st[16:0];
    o.pitch_angle = pitch_st[15:0];
    o.yaw_angle   = yaw_st[16:0];
    return o;
  endfunction

  assign pending = attitude_q.size();

  // Track register writes, predict on accepted samples, compare result words.
  always @(posedge clk) begin
    result_t exp_w;
    if (rst) begin
      mount_code <= ALIGN_0;
      yaw_bias   <= '0;
      rate_gain  <= GYRO_SCALE_RST;
      alpha_w    <= ALPHA_RST;
      roll_st = 0; pitch_st = 0; yaw_st = 0;
      attitude_q.delete();
      fail_count   <= 0;
      result_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ALIGN:      mount_code <= cfg_data[1:0];
          CFG_YAW_OFFSET: yaw_bias   <= cfg_data[15:0];
          CFG_GYRO_SCALE: rate_gain  <= cfg_data;
          CFG_ALPHA:      alpha_w    <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (sample_valid && sample_ready) attitude_q.push_back(predict_attitude(sample));
      if (result_valid && result_ready) begin
        result_count <= result_count + 1;
        if (attitude_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("Unexpected result word %h", result);
        end else begin
          exp_w = attitude_q.pop_front();
          if (result !== exp_w) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("Result word mismatch: roll %0d/%0d pitch %0d/%0d yaw %0d/%0d upd %b/%b",
                       exp_w.roll_angle, result.roll_angle, exp_w.pitch_angle,
                       result.pitch_angle, exp_w.yaw_angle, result.yaw_angle,
                       exp_w.was_updated, result.was_updated);
          end
        end
      end
    end
  end
endmodule

/* dv/tb_top.sv */
// Testbench top for the attitude estimator: clock, reset, register writes,
// sample stimulus and the verdict. Depends on imuca_pkg and imuca_checker.
module tb_top;
  import imuca_pkg::*;

  logic clk, rst;
  logic sample_valid, sample_ready, result_valid, result_ready;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [23:0] cfg_data;
  sample_t sample;
  result_t result;
  int fail_count, pending, result_count;
  int send_idle, recv_stall;
  int cycles;

  imu_complementary_attitude_top DUT (.*);
  imuca_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Run limit: ends a hung run with the mismatch verdict.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 1500000) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Receiver stalls at random.
  always @(posedge clk) begin
    if (rst) result_ready <= 1'b0;
    else result_ready <= ($urandom_range(99) >= recv_stall);
  end

  function automatic logic [15:0] pick16();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(64) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  // Each write drops cfg_valid before the next one starts.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // After each word is taken, sample_valid drops while the block is still busy.
  task automatic send_word(sample_t s);
    while ($urandom_range(99) < send_idle) @(posedge clk);
    sample_valid <= 1'b1;
    sample       <= s;
    do @(posedge clk); while (!sample_ready);
    sample_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for every expected word, then for the block to go quiet.
  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic send_random(int n);
    sample_t s;
    for (int i = 0; i < n; i++) begin
      s.accel_x = pick16(); s.accel_y = pick16(); s.accel_z = pick16();
      s.rate_x = pick16(); s.rate_y = pick16(); s.rate_z = pick16();
      case ($urandom_range(9))
        0: s.elapsed_us = 16'd0;
        1: s.elapsed_us = 16'hffff;
        2, 3: s.elapsed_us = 16'($urandom);
        default: s.elapsed_us = 16'($urandom_range(20000, 500));
      endcase
      send_word(s);
    end
  endtask

  initial begin
    sample_t s;
    int idle_tab[4] = '{0, 52, 0, 18};
    int stall_tab[4] = '{0, 0, 52, 18};
    rst = 1'b1;
    sample_valid = 1'b0;
    sample = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle = 0;
    recv_stall = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words: field extremes, zero vector, zero and maximum elapsed time.
    s = '0;
    send_word(s);
    s = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hffff};
    send_word(s);
    s = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'hffff};
    send_word(s);
    s = '{16'h0000, 16'h0000, 16'h0000, 16'h7fff, 16'h7fff, 16'h8000, 16'h0000};
    send_word(s);
    s = '{16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'hff00, 16'h0040, 16'd1000};
    send_word(s);
    s = '{16'h0000, 16'h0000, 16'hc000, 16'h0000, 16'h0000, 16'h0000, 16'd1};
    send_word(s);
    drain();
    // Every mounting rotation with saturating negation and a yaw bias.
    write_reg(CFG_YAW_OFFSET, 24'h007fff);
    for (int a = 0; a < 4; a++) begin
      write_reg(CFG_ALIGN, 24'(a));
      s = '{16'h8000, 16'h8000, 16'h4000, 16'h8000, 16'h8000, 16'h8000, 16'd5000};
      send_word(s);
      s = '{16'h1234, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'd300};
      send_word(s);
      drain();
    end
    write_reg(CFG_YAW_OFFSET, 24'h008000);
    write_reg(8'd200, 24'hffffff);
    send_random(3);
    drain();

    // Random phases over varying register settings and idle patterns.
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_ALIGN, 24'($urandom_range(3)));
      write_reg(CFG_YAW_OFFSET, (ph % 3 == 0) ? 24'h0 : 24'($urandom));
      write_reg(CFG_GYRO_SCALE, (ph == 1) ? 24'hffffff : (ph == 2) ? 24'h0 :
                                24'($urandom));
      write_reg(CFG_ALPHA, (ph == 1) ? 24'h0 : (ph == 2) ? 24'hffff : 24'($urandom));
      send_idle = idle_tab[ph % 4];
      recv_stall = stall_tab[ph % 4];
      send_random(100);
      drain();
      send_random(100);
      drain();
    end
    drain();
    $display("Covered %0d result words over 8 register settings, four mount codes",
             result_count);
    $display("and idle patterns on both channels.");
    if (fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
